@@ src/segment_crossing_test_defines.svh @@
// Assertion macros for the verification file of segment_crossing_test (scx_checker).
// Depends on nothing; include it by bare file name.
`ifndef SEGMENT_CROSSING_TEST_DEFINES_SVH
`define SEGMENT_CROSSING_TEST_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SCX_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segment_crossing_test: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SCX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("segment_crossing_test: next-cycle check failed");

`endif

@@ src/scx_pkg.sv @@
// Package for segment_crossing_test: widths, payload types and register indexes.
// Used by every module of the block; depends on nothing.
`default_nettype none

package scx_pkg;

   localparam int COORD_BITS    = 24;
   localparam int FRACTION_BITS = 16;

   // Derived widths of the datapath.
   localparam int DIFF_W      = COORD_BITS + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int CROSS_W     = PROD_W + 1;
   localparam int MAG_W       = CROSS_W;
   localparam int DEN_W       = MAG_W + 1;
   localparam int CSR_INDEX_W = 2;

   // Four cross products, each built from four coordinate differences.
   localparam int NUM_CROSS  = 4;
   localparam int XP_OPNDS   = 4;
   localparam int XP_B_SIDE  = 0;
   localparam int XP_A_SIDE  = 1;
   localparam int XP_E_DIST  = 2;
   localparam int XP_S_DIST  = 3;

   // The last quotient bit is formed on the way into the output register.
   localparam int DIV_STAGES = FRACTION_BITS - 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [CROSS_W-1:0]    cross_type;
   typedef logic [MAG_W-1:0]             mag_type;
   typedef logic [DEN_W-1:0]             den_type;
   typedef logic [FRACTION_BITS-1:0]     frac_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_A_X = 2'd0,
      CSR_LINE_A_Y = 2'd1,
      CSR_LINE_B_X = 2'd2,
      CSR_LINE_B_Y = 2'd3
   } csr_index_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      logic     crosses;
      frac_type crossing_fraction;
   } rsp_type;

   typedef struct packed {
      coord_type a_x;
      coord_type a_y;
      coord_type b_x;
      coord_type b_y;
   } line_type;

   typedef struct packed {
      cross_type b_side;
      cross_type a_side;
      cross_type e_dist;
      cross_type s_dist;
   } cross_set_type;

   typedef struct packed {
      logic    crosses;
      mag_type num;
      den_type den;
   } div_in_type;

endpackage

`default_nettype wire

@@ src/scx_cross.sv @@
// Three-stage cross product pipeline: differences, products, final subtraction.
// Depends on scx_pkg.
`default_nettype none

module scx_cross (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  scx_pkg::req_type       in_data,
   input  scx_pkg::line_type      line,
   output logic                   out_valid,
   input  logic                   out_stall,
   output scx_pkg::cross_set_type out_data
);
   import scx_pkg::*;

   function automatic diff_type sub_coord(coord_type p, coord_type q);
      return diff_type'(p) - diff_type'(q);
   endfunction

   diff_type      opnd_in [NUM_CROSS][XP_OPNDS];
   diff_type      opnd_ff [NUM_CROSS][XP_OPNDS];
   prod_type      pl_in [NUM_CROSS];
   prod_type      pr_in [NUM_CROSS];
   prod_type      pl_ff [NUM_CROSS];
   prod_type      pr_ff [NUM_CROSS];
   cross_type     cross_in [NUM_CROSS];
   cross_set_type res_in;
   cross_set_type res_ff;

   logic v1_ff, v2_ff, v3_ff;
   logic ready1, ready2, ready3;

   assign ready3   = !v3_ff || !out_stall;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_stall = !ready1;

   // Each cross product is opnd[0] * opnd[1] - opnd[2] * opnd[3].
   always_comb begin
      opnd_in[XP_B_SIDE][0] = sub_coord(in_data.end_x, in_data.start_x);
      opnd_in[XP_B_SIDE][1] = sub_coord(line.b_y, in_data.start_y);
      opnd_in[XP_B_SIDE][2] = sub_coord(in_data.end_y, in_data.start_y);
      opnd_in[XP_B_SIDE][3] = sub_coord(line.b_x, in_data.start_x);

      opnd_in[XP_A_SIDE][0] = sub_coord(in_data.end_x, in_data.start_x);
      opnd_in[XP_A_SIDE][1] = sub_coord(line.a_y, in_data.start_y);
      opnd_in[XP_A_SIDE][2] = sub_coord(in_data.end_y, in_data.start_y);
      opnd_in[XP_A_SIDE][3] = sub_coord(line.a_x, in_data.start_x);

      opnd_in[XP_E_DIST][0] = sub_coord(line.b_x, line.a_x);
      opnd_in[XP_E_DIST][1] = sub_coord(in_data.end_y, line.a_y);
      opnd_in[XP_E_DIST][2] = sub_coord(line.b_y, line.a_y);
      opnd_in[XP_E_DIST][3] = sub_coord(in_data.end_x, line.a_x);

      opnd_in[XP_S_DIST][0] = sub_coord(line.b_x, line.a_x);
      opnd_in[XP_S_DIST][1] = sub_coord(in_data.start_y, line.a_y);
      opnd_in[XP_S_DIST][2] = sub_coord(line.b_y, line.a_y);
      opnd_in[XP_S_DIST][3] = sub_coord(in_data.start_x, line.a_x);
   end

   always_comb begin
      for (int i = 0; i < NUM_CROSS; i++) begin
         pl_in[i]    = prod_type'(opnd_ff[i][0] * opnd_ff[i][1]);
         pr_in[i]    = prod_type'(opnd_ff[i][2] * opnd_ff[i][3]);
         cross_in[i] = cross_type'(pl_ff[i]) - cross_type'(pr_ff[i]);
      end
      res_in.b_side = cross_in[XP_B_SIDE];
      res_in.a_side = cross_in[XP_A_SIDE];
      res_in.e_dist = cross_in[XP_E_DIST];
      res_in.s_dist = cross_in[XP_S_DIST];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= in_valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) opnd_ff <= opnd_in;
      if (ready2) begin
         pl_ff <= pl_in;
         pr_ff <= pr_in;
      end
      if (ready3) res_ff <= res_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = res_ff;

endmodule

`default_nettype wire

@@ src/scx_classify.sv @@
// Two-stage side test and magnitude sum that prepares the fraction division.
// Depends on scx_pkg.
`default_nettype none

module scx_classify (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  scx_pkg::cross_set_type in_data,
   output logic                   out_valid,
   input  logic                   out_stall,
   output scx_pkg::div_in_type    out_data
);
   import scx_pkg::*;

   typedef struct packed {
      logic    crosses;
      mag_type mag_s;
      mag_type mag_e;
   } side_type;

   // Strictly opposite sides: both nonzero and of different sign.
   function automatic logic strictly_opposite(cross_type p, cross_type q);
      return (p != '0) && (q != '0) && (p[CROSS_W-1] != q[CROSS_W-1]);
   endfunction

   function automatic mag_type magnitude(cross_type v);
      return v[CROSS_W-1] ? mag_type'(-v) : mag_type'(v);
   endfunction

   side_type   a_in, a_ff;
   div_in_type b_in, b_ff;
   logic       a_valid_ff, b_valid_ff;
   logic       ready_a, ready_b;

   assign ready_b  = !b_valid_ff || !out_stall;
   assign ready_a  = !a_valid_ff || ready_b;
   assign in_stall = !ready_a;

   always_comb begin
      a_in.crosses = strictly_opposite(in_data.b_side, in_data.a_side)
                     && strictly_opposite(in_data.e_dist, in_data.s_dist);
      a_in.mag_s   = magnitude(in_data.s_dist);
      a_in.mag_e   = magnitude(in_data.e_dist);

      b_in.crosses = a_ff.crosses;
      b_in.num     = a_ff.mag_s;
      b_in.den     = den_type'(a_ff.mag_s) + den_type'(a_ff.mag_e);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (ready_a) a_valid_ff <= in_valid;
         if (ready_b) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) a_ff <= a_in;
      if (ready_b) b_ff <= b_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_ff;

endmodule

`default_nettype wire

@@ src/scx_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage for the crossing fraction.
// Depends on scx_pkg.
`default_nettype none

module scx_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  scx_pkg::div_in_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output scx_pkg::rsp_type    out_data
);
   import scx_pkg::*;

   typedef struct packed {
      logic     crosses;
      den_type  rem;
      den_type  den;
      frac_type quo;
   } div_state_type;

   // One restoring step. The remainder never exceeds the divisor, so it fits den_type.
   function automatic div_state_type div_step(div_state_type s);
      logic [DEN_W:0] shifted;
      logic [DEN_W:0] den_ext;
      logic           ge;
      div_state_type  r;
      shifted = {s.rem, 1'b0};
      den_ext = {1'b0, s.den};
      ge      = shifted >= den_ext;
      r       = s;
      r.rem   = ge ? den_type'(shifted - den_ext) : den_type'(shifted);
      r.quo   = {s.quo[FRACTION_BITS-2:0], ge};
      return r;
   endfunction

   div_state_type first_state;
   div_state_type last_state;
   div_state_type src      [DIV_STAGES];
   div_state_type stage_in [DIV_STAGES];
   div_state_type stage_ff [DIV_STAGES];
   logic          valid_src [DIV_STAGES];
   logic          valid_ff  [DIV_STAGES];
   logic          ready     [DIV_STAGES+1];

   assign first_state = '{crosses: in_data.crosses, rem: den_type'(in_data.num),
                          den: in_data.den, quo: '0};

   assign ready[DIV_STAGES] = !out_stall;
   assign in_stall          = !ready[0];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign valid_src[k] = in_valid;
         assign src[k]       = first_state;
      end else begin : g_next
         assign valid_src[k] = valid_ff[k-1];
         assign src[k]       = stage_ff[k-1];
      end

      assign ready[k]    = !valid_ff[k] || ready[k+1];
      assign stage_in[k] = div_step(src[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready[k]) begin
            valid_ff[k] <= valid_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ready[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // The final quotient bit is resolved here and registered by the output stage.
   assign last_state                 = div_step(stage_ff[DIV_STAGES-1]);
   assign out_valid                  = valid_ff[DIV_STAGES-1];
   assign out_data.crosses           = last_state.crosses;
   assign out_data.crossing_fraction = last_state.crosses ? last_state.quo : '0;

endmodule

`default_nettype wire

@@ src/segment_crossing_test.sv @@
// Top level of segment_crossing_test: reference segment registers, pipeline, output register.
// Depends on scx_pkg, scx_cross, scx_classify and scx_divider.
`default_nettype none

// Tests a moving segment S-E, one per req_ transfer, against the reference segment A-B held in
// the four csr_ registers (signed Q16.8), and returns one rsp_ transfer per request, in order:
// crosses is set only when each segment's endpoints lie strictly on opposite sides of the other's
// line, and crossing_fraction then gives |dS| / (|dS| + |dE|) along S-E as unsigned Q0.16,
// truncated (0 when there is no crossing). The block takes one request every cycle unless req_stall
// is high; each request passes in order through the cross product stages, the side test and
// magnitude sum stages, the one-bit-per-stage quotient pipeline and the output register. Each
// stage holds its item while the one after it is full and stalled, so empty stages keep filling
// while a result waits. Write the reference registers only while no transfer is in flight.
module segment_crossing_test (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  scx_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output scx_pkg::rsp_type             rsp_payload,
   input  logic                         csr_wr_en,
   input  logic [scx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [scx_pkg::COORD_BITS-1:0]  csr_wdata
);
   import scx_pkg::*;

   line_type      line_in, line_ff;
   cross_set_type xp_data;
   div_in_type    cl_data;
   rsp_type       div_data;
   rsp_type       rsp_ff;
   logic          rsp_valid_in, rsp_valid_ff;
   logic          xp_valid, xp_stall;
   logic          cl_valid, cl_stall;
   logic          div_valid, div_stall;
   logic          out_ready;

   always_comb begin
      line_in = line_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LINE_A_X: line_in.a_x = coord_type'(csr_wdata);
            CSR_LINE_A_Y: line_in.a_y = coord_type'(csr_wdata);
            CSR_LINE_B_X: line_in.b_x = coord_type'(csr_wdata);
            CSR_LINE_B_Y: line_in.b_y = coord_type'(csr_wdata);
            default: line_in = line_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
      end else begin
         line_ff <= line_in;
      end
   end

   scx_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_payload),
      .line      (line_ff),
      .out_valid (xp_valid),
      .out_stall (xp_stall),
      .out_data  (xp_data)
   );

   scx_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xp_valid),
      .in_stall  (xp_stall),
      .in_data   (xp_data),
      .out_valid (cl_valid),
      .out_stall (cl_stall),
      .out_data  (cl_data)
   );

   scx_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cl_valid),
      .in_stall  (cl_stall),
      .in_data   (cl_data),
      .out_valid (div_valid),
      .out_stall (div_stall),
      .out_data  (div_data)
   );

   // The output register takes a new result whenever it is empty or its transfer completes.
   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign div_stall    = !out_ready;
   assign rsp_valid_in = out_ready ? div_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_ff <= div_data;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

@@ src/scx_checker.sv @@
// Port-level checks for segment_crossing_test and the bind that attaches them.
// Depends on scx_pkg and segment_crossing_test_defines.svh.
`default_nettype none

`include "segment_crossing_test_defines.svh"

module scx_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input scx_pkg::rsp_type rsp_payload
);
   import scx_pkg::*;

   // A stalled result holds its value until the transfer completes.
   `SCX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // With the output register empty, every stage can move, so requests are never stalled.
   `SCX_ASSERT_IMPLIES(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall)

   // A result without a crossing carries a zero fraction.
   `SCX_ASSERT_IMPLIES(a_zero_fraction, clock, reset, rsp_valid && !rsp_payload.crosses, rsp_payload.crossing_fraction == '0)

   // Reset empties the pipeline, so no result shows right after it.
   `SCX_ASSERT_IMPLIES(a_idle_after_reset, clock, reset, $past(reset), !rsp_valid)

endmodule

bind segment_crossing_test scx_checker u_scx_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
